[rtl/assert_macros.svh]
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/alu16_pkg.sv]
package alu16_pkg;

  // Operation classes after decode.
  typedef enum logic [4:0] {
    OP_INC, OP_DEC, OP_NEG, OP_NOT, OP_ADD, OP_SUB, OP_CMP, OP_MUL, OP_IMUL,
    OP_DIV, OP_IDIV, OP_AND, OP_OR, OP_SHL, OP_SAL, OP_SHR, OP_SAR, OP_NONE
  } alu_op_t;

  localparam logic [4:0] REQ_REG_FIRST = 5'd17;
  localparam logic [4:0] REQ_REG_LAST  = 5'd29;
  localparam logic [4:0] REQ_REG_BIAS  = 5'd13;

  localparam logic [15:0] SIGN_MASK16 = 16'h8000;
  localparam logic [15:0] SMAX16      = 16'h7FFF;
  localparam logic [15:0] UMAX16      = 16'hFFFF;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BE_IDLE, BE_MUL, BE_DIV, BE_DONE
  } be_state_t;

  // Decoded request carried from front to back.
  typedef struct packed {
    alu_op_t     op;
    logic        regform;
    logic [15:0] src;
    logic [2:0]  dst;
  } dec_req_t;

  typedef struct packed {
    logic [15:0] value;
    logic        cf;
    logic        zf;
    logic        sf;
    logic        of;
    logic        derr;
  } result_t;

endpackage

[rtl/alu16_front.sv]
module alu16_front import alu16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [4:0] in_req_type,
  input  logic [15:0] in_source_operand,
  input  logic [2:0] in_dest_index,
  output logic       q_valid,
  output dec_req_t   q_data,
  input  logic       q_take
);

  // Two-entry queue of decoded requests.
  dec_req_t  slot_r [2];
  logic      rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  dec_req_t  dec;
  logic      push_ok, pop_ok;

  // Classify the opcode.
  always_comb begin
    dec.regform = (in_req_type inside {[REQ_REG_FIRST:REQ_REG_LAST]});
    dec.src     = in_source_operand;
    dec.dst     = in_dest_index;
    if (in_req_type > REQ_REG_LAST) begin
      dec.op = OP_NONE;
    end else if (dec.regform) begin
      dec.op = alu_op_t'(in_req_type - REQ_REG_BIAS);
    end else begin
      dec.op = alu_op_t'(in_req_type);
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop_ok  = q_take && q_valid;
  assign q_data  = slot_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[rtl/alu16_back.sv]
module alu16_back import alu16_pkg::*; #(
  parameter int NUM_REGS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  dec_req_t q_data,
  output logic     q_take,
  output logic     res_valid,
  output result_t  res_data,
  input  logic     res_take
);

  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Reciprocal of the register count, scaled so a 16-bit index divides exactly.
  localparam int IDX_SHIFT = 16 + IW;
  localparam logic [17:0] IDX_RECIP =
    18'(((64'd1 << IDX_SHIFT) + 64'(NUM_REGS) - 64'd1) / 64'(NUM_REGS));

  be_state_t state_r, state_nxt;
  logic [15:0] regs_r [NUM_REGS];
  dec_req_t   cur_r;
  logic [15:0] a_r, b_r;
  logic [31:0] prod_r;
  logic [15:0] quo_r, rem_r, dvs_r;
  logic [4:0]  step_r;
  logic        qneg_r, sneg_r;
  logic        rv_r;
  result_t     out_r;
  logic [IW-1:0] sidx, didx, tgt;
  logic [15:0] rs, rd, bsel;

  // Reduce an index modulo the register count by reciprocal multiplication.
  function automatic logic [IW-1:0] reg_index(logic [15:0] x);
    logic [33:0] prod;
    logic [15:0] quot;
    prod = {18'd0, x} * {16'd0, IDX_RECIP};
    quot = 16'(prod >> IDX_SHIFT);
    return IW'(x - 16'(quot * 16'(NUM_REGS)));
  endfunction

  // Reduce indexes modulo the register count.
  always_comb begin
    sidx = reg_index(q_data.src);
    didx = reg_index({13'd0, q_data.dst});
    rs   = regs_r[sidx];
    rd   = regs_r[didx];
    bsel = q_data.regform ? rs : q_data.src;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE: begin
        if (q_valid && !rv_r) begin
          if (q_data.op == OP_MUL || q_data.op == OP_IMUL) begin
            state_nxt = BE_MUL;
          end else if ((q_data.op == OP_DIV || q_data.op == OP_IDIV) && bsel != 16'd0) begin
            state_nxt = BE_DIV;
          end else begin
            state_nxt = BE_IDLE;
          end
        end
      end
      BE_MUL: state_nxt = BE_DONE;
      BE_DIV: if (step_r == 5'd15) state_nxt = BE_DONE;
      BE_DONE: state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    q_take = (state_r == BE_IDLE) && q_valid && !rv_r;
  end

  assign res_valid = rv_r;
  assign res_data  = out_r;

  // Result of the operations that need no multiply or divide sequence.
  result_t quick;
  logic    quick_wr;
  logic [IW-1:0] quick_tgt;
  logic [16:0] sum, dif;
  logic [32:0] shl;
  logic [15:0] sarv;
  logic        zs;
  always_comb begin
    quick = '0;
    quick.value = rd;
    quick_wr = 1'b1;
    quick_tgt = didx;
    zs = 1'b0;
    sum = {1'b0, rd} + {1'b0, bsel};
    dif = {1'b0, rd} - {1'b0, bsel};
    shl = {17'd0, rd} << bsel[4:0];
    sarv = 16'($signed(rd) >>> bsel[3:0]);
    case (q_data.op)
      OP_INC, OP_DEC: begin
        quick_tgt = sidx;
        quick.value = (q_data.op == OP_INC) ? rs + 16'd1 : rs - 16'd1;
        zs = 1'b1;
      end
      OP_NEG: begin
        quick_tgt = sidx;
        if (rs == SIGN_MASK16) begin
          quick.value = rs;
          quick.of = 1'b1;
          quick_wr = 1'b0;
        end else begin
          quick.cf = (rs == 16'd0);
          quick.value = 16'd0 - rs;
          zs = 1'b1;
        end
      end
      OP_NOT: begin
        quick_tgt = sidx;
        quick.value = ~rs;
      end
      OP_ADD: begin
        quick.value = sum[15:0];
        quick.cf = sum[16];
        quick.of = (rd[15] == bsel[15]) && (sum[15] != rd[15]);
        zs = 1'b1;
      end
      OP_SUB, OP_CMP: begin
        quick.value = dif[15:0];
        quick.cf = dif[16];
        quick.of = (rd[15] != bsel[15]) && (dif[15] != rd[15]);
        zs = 1'b1;
        quick_wr = (q_data.op == OP_SUB);
      end
      OP_DIV, OP_IDIV: begin
        quick.derr = 1'b1;
        quick_wr = 1'b0;
      end
      OP_AND: begin quick.value = rd & bsel; zs = 1'b1; end
      OP_OR:  begin quick.value = rd | bsel; zs = 1'b1; end
      OP_SHL, OP_SAL: begin
        if (bsel > 16'd16) begin
          quick.value = 16'd0;
        end else begin
          quick.value = shl[15:0];
          quick.cf = shl[16];
        end
        zs = 1'b1;
      end
      OP_SHR: begin
        if (bsel > 16'd16) begin
          quick.value = 16'd0;
        end else if (bsel == 16'd16) begin
          quick.value = 16'd0;
          quick.cf = rd[15];
        end else begin
          quick.value = rd >> bsel[3:0];
          if (bsel != 16'd0) quick.cf = rd[bsel[3:0] - 4'd1];
        end
        zs = 1'b1;
      end
      OP_SAR: begin
        if (bsel >= 16'd16) begin
          quick.value = {16{rd[15]}};
          quick.cf = rd[15];
        end else begin
          quick.value = sarv;
          if (bsel != 16'd0) quick.cf = rd[bsel[3:0] - 4'd1];
        end
        zs = 1'b1;
      end
      default: quick_wr = 1'b0;
    endcase
    quick.zf = zs && (quick.value == 16'd0);
    quick.sf = zs && quick.value[15];
  end

  // Restoring divider step on magnitudes.
  logic [16:0] trial;
  logic [15:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[14:0], quo_r[15]};
    trial  = {rem_r, quo_r[15]} - {1'b0, dvs_r};
  end

  logic [15:0] qfin, mval;
  logic        mofl;
  always_comb begin
    qfin = qneg_r ? 16'd0 - quo_r : quo_r;
    mofl = (cur_r.op == OP_MUL) ? (prod_r[31:16] != 16'd0)
         : !((prod_r[31:15] == 17'd0) || (prod_r[31:15] == 17'h1FFFF));
    mval = prod_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
      rv_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      if (res_take && rv_r) rv_r <= 1'b0;
      if (q_take && state_nxt == BE_IDLE) begin
        rv_r <= 1'b1;
        if (quick_wr) regs_r[quick_tgt] <= quick.value;
      end
      if (state_r == BE_DONE) begin
        rv_r <= 1'b1;
        if (cur_r.op == OP_MUL || cur_r.op == OP_IMUL) begin
          regs_r[tgt] <= mval;
        end else begin
          regs_r[tgt] <= qfin;
        end
      end
    end
  end

  assign tgt = reg_index({13'd0, cur_r.dst});

  // Result register and datapath registers for the long operations.
  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_r <= q_data;
      a_r <= rd;
      b_r <= bsel;
      out_r <= quick;
      step_r <= 5'd0;
      qneg_r <= (q_data.op == OP_IDIV) && (rd[15] ^ bsel[15]);
      quo_r <= (q_data.op == OP_IDIV && rd[15]) ? 16'd0 - rd : rd;
      dvs_r <= (q_data.op == OP_IDIV && bsel[15]) ? 16'd0 - bsel : bsel;
      rem_r <= 16'd0;
      sneg_r <= (q_data.op == OP_IMUL);
    end
    if (state_r == BE_MUL) begin
      if (sneg_r) prod_r <= 32'($signed(a_r) * $signed(b_r));
      else        prod_r <= 32'(a_r * b_r);
    end
    if (state_r == BE_DIV) begin
      step_r <= step_r + 5'd1;
      if (!trial[16]) begin
        rem_r <= trial[15:0];
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
    if (state_r == BE_DONE) begin
      out_r <= '0;
      if (cur_r.op == OP_MUL || cur_r.op == OP_IMUL) begin
        out_r.value <= mval;
        out_r.cf <= mofl;
        out_r.of <= mofl;
      end else begin
        out_r.value <= qfin;
      end
    end
  end

endmodule

[rtl/alu16_with_register_file.sv]
// Channel   Ports                                    Handshake
// input     in_req_type, in_source_operand, ...      in_push / in_full
// result    out_result_value, out_*_flag, ...        out_pop / out_empty
//
// On an idle block a simple request passes from the front queue into the
// result register. MUL and IMUL pass through the queue, the multiply
// stage and the write-back. DIV and IDIV with a nonzero divisor run the 16
// steps of the one-bit-per-cycle divider before the write-back.
// Reset clears the registers, the front queue and the result valid bit.
// A result waiting to be popped stalls the execute unit; the front queue
// keeps accepting until its two entries are full.
module alu16_with_register_file import alu16_pkg::*; #(
  parameter int NUM_REGS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [4:0]  in_req_type,
  input  logic [15:0] in_source_operand,
  input  logic [2:0]  in_dest_index,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_result_value,
  output logic        out_carry_flag,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_overflow_flag,
  output logic        out_divide_error
);

  logic     q_valid, q_take, res_valid;
  dec_req_t q_data;
  result_t  res_data;

  alu16_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_source_operand,
    .in_dest_index, .q_valid, .q_data, .q_take
  );

  alu16_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_take, .res_valid, .res_data,
    .res_take(out_pop)
  );

  assign out_empty         = !res_valid;
  assign out_result_value  = res_data.value;
  assign out_carry_flag    = res_data.cf;
  assign out_zero_flag     = res_data.zf;
  assign out_sign_flag     = res_data.sf;
  assign out_overflow_flag = res_data.of;
  assign out_divide_error  = res_data.derr;

endmodule

[rtl/alu16_checker.sv]
`include "assert_macros.svh"
module alu16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_result_value,
  input logic        out_zero_flag,
  input logic        out_sign_flag,
  input logic        out_divide_error,
  input logic        out_carry_flag,
  input logic        out_overflow_flag
);
  `ASSERT_IMPL(a_zf_value, clk, rst_n, !out_empty && out_zero_flag,
    out_result_value == 16'd0, "zero flag with nonzero value")
  `ASSERT_IMPL(a_sf_bit, clk, rst_n, !out_empty && out_sign_flag,
    out_result_value[15], "sign flag without bit 15")
  `ASSERT_IMPL(a_derr_flags, clk, rst_n, !out_empty && out_divide_error,
    !out_carry_flag && !out_zero_flag && !out_overflow_flag, "flags set on divide error")
  `ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_result_value), "waiting result changed")
endmodule

bind alu16_with_register_file alu16_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_result_value,
  .out_zero_flag, .out_sign_flag, .out_divide_error, .out_carry_flag,
  .out_overflow_flag
);

[sim/tb.sv]
module tb import alu16_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREGS = 8;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [4:0] REQ_OPC_LAST = 5'd31;

  // Expected result of one request.
  typedef struct {
    logic [15:0] value;
    logic        cf;
    logic        zf;
    logic        sf;
    logic        of;
    logic        derr;
  } alu_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [4:0]  in_req_type;
  logic [15:0] in_source_operand;
  logic [2:0]  in_dest_index;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_result_value;
  logic        out_carry_flag;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_overflow_flag;
  logic        out_divide_error;

  alu16_with_register_file #(.NUM_REGS(NREGS)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_source_operand(in_source_operand),
    .in_dest_index    (in_dest_index),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_value (out_result_value),
    .out_carry_flag   (out_carry_flag),
    .out_zero_flag    (out_zero_flag),
    .out_sign_flag    (out_sign_flag),
    .out_overflow_flag(out_overflow_flag),
    .out_divide_error (out_divide_error)
  );

  // Shadow copy of the architectural state.
  logic [15:0] shadow_regs [NREGS];
  alu_result_t pending_results [$];
  int          mismatch_count;
  bit          quiet_mode;
  bit          hold_pop;
  int          idle_cycles;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] sar16(logic [15:0] v, int n);
    logic [15:0] r;
    r = v;
    for (int k = 0; k < n; k++) begin
      r = {r[15], r[15:1]};
    end
    return r;
  endfunction

  // Execute one instruction on the shadow state and return its result.
  function automatic alu_result_t execute_instruction(logic [4:0] opc, logic [15:0] src,
                                                      logic [2:0] dst);
    alu_result_t r;
    alu_op_t     op;
    bit          regform;
    int          sidx;
    int          tgt;
    logic [15:0] a;
    logic [15:0] b;
    logic [16:0] wide;
    logic [31:0] prod;
    int          sprod;
    int          squot;
    bit          wr;
    bit          zs;
    logic [15:0] res;
    bit          cf;
    bit          of;
    bit          derr;
    regform = (opc >= REQ_REG_FIRST) && (opc <= REQ_REG_LAST);
    if (opc > REQ_REG_LAST) op = OP_NONE;
    else if (regform) op = alu_op_t'(opc - REQ_REG_BIAS);
    else op = alu_op_t'(opc);
    sidx = src % NREGS;
    a = shadow_regs[dst];
    b = regform ? shadow_regs[sidx] : src;
    tgt = dst;
    res = a;
    wr = 1;
    zs = 0;
    cf = 0;
    of = 0;
    derr = 0;
    case (op)
      OP_INC, OP_DEC: begin
        tgt = sidx;
        res = shadow_regs[sidx] + ((op == OP_INC) ? 16'd1 : 16'hFFFF);
        zs = 1;
      end
      OP_NEG: begin
        tgt = sidx;
        res = shadow_regs[sidx];
        if (res == SIGN_MASK16) begin
          of = 1;
          wr = 0;
        end else begin
          cf = (res == 16'd0);
          res = -res;
          zs = 1;
        end
      end
      OP_NOT: begin
        tgt = sidx;
        res = ~shadow_regs[sidx];
      end
      OP_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        cf = wide[16];
        res = wide[15:0];
        of = (a[15] == b[15]) && (res[15] != a[15]);
        zs = 1;
      end
      OP_SUB, OP_CMP: begin
        res = a - b;
        cf = a < b;
        of = (a[15] != b[15]) && (res[15] != a[15]);
        zs = 1;
        if (op == OP_CMP) wr = 0;
      end
      OP_MUL: begin
        prod = a * b;
        cf = prod > UMAX16;
        of = cf;
        res = prod[15:0];
      end
      OP_IMUL: begin
        sprod = $signed(a) * $signed(b);
        cf = (sprod < -32768) || (sprod > int'(SMAX16));
        of = cf;
        res = sprod[15:0];
      end
      OP_DIV: begin
        if (b == 16'd0) begin
          derr = 1;
          wr = 0;
        end else begin
          res = a / b;
        end
      end
      OP_IDIV: begin
        if (b == 16'd0) begin
          derr = 1;
          wr = 0;
        end else begin
          squot = int'($signed(a)) / int'($signed(b));
          res = squot[15:0];
        end
      end
      OP_AND: begin
        res = a & b;
        zs = 1;
      end
      OP_OR: begin
        res = a | b;
        zs = 1;
      end
      OP_SHL, OP_SAL: begin
        if (b > 16) begin
          res = 16'd0;
        end else begin
          wide = {1'b0, a} << b;
          cf = wide[16];
          res = wide[15:0];
        end
        zs = 1;
      end
      OP_SHR: begin
        if (b > 16) begin
          res = 16'd0;
        end else if (b == 16) begin
          res = 16'd0;
          cf = a[15];
        end else begin
          if (b > 0) cf = a[b - 1];
          res = a >> b;
        end
        zs = 1;
      end
      OP_SAR: begin
        if (b >= 16) begin
          res = a[15] ? 16'hFFFF : 16'd0;
          cf = a[15];
        end else begin
          if (b > 0) cf = a[b - 1];
          res = sar16(a, b);
        end
        zs = 1;
      end
      default: wr = 0;
    endcase
    if (wr) shadow_regs[tgt] = res;
    r.value = res;
    r.cf = cf;
    r.zf = zs && (res == 16'd0);
    r.sf = zs && res[15];
    r.of = of;
    r.derr = derr;
    return r;
  endfunction

  // Offer one request and wait until the block takes it.
  task automatic send_request(logic [4:0] opc, logic [15:0] src, logic [2:0] dst);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 6) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push <= 1'b1;
    in_req_type <= opc;
    in_source_operand <= src;
    in_dest_index <= dst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_results.push_back(execute_instruction(opc, src, dst));
  endtask

  task automatic load_register(int idx, logic [15:0] v);
    // Clear with AND 0, then OR the value in.
    send_request(5'(OP_AND), 16'd0, 3'(idx));
    send_request(5'(OP_OR), v, 3'(idx));
  endtask

  task automatic test_directed_edges();
    load_register(1, 16'h8000);
    send_request(5'(OP_NEG), 16'd1, 3'd0);
    send_request(5'(OP_NEG), 16'd2, 3'd0);
    send_request(5'(OP_DEC), 16'hFFF8, 3'd0);
    send_request(5'(OP_INC), 16'd0, 3'd0);
    send_request(5'(OP_ADD), 16'hFFFF, 3'd0);
    send_request(5'(OP_ADD), 16'h8000, 3'd1);
    send_request(5'(OP_SUB), 16'hFFFF, 3'd2);
    send_request(5'(OP_CMP), 16'h7FFF, 3'd1);
    send_request(5'(OP_DIV), 16'd0, 3'd1);
    send_request(5'(OP_IDIV), 16'd0, 3'd1);
    load_register(3, 16'h8000);
    load_register(4, 16'hFFFF);
    send_request(5'(OP_IDIV) + REQ_REG_BIAS, 16'd4, 3'd3);
    send_request(5'(OP_IMUL), 16'h8000, 3'd4);
    send_request(5'(OP_MUL), 16'hFFFF, 3'd4);
    send_request(5'(OP_SHL), 16'd17, 3'd4);
    send_request(5'(OP_SAR), 16'd20, 3'd1);
    send_request(5'(OP_SHR), 16'd16, 3'd1);
    send_request(5'(OP_NOT), 16'd5, 3'd0);
    send_request(REQ_OPC_LAST, 16'hFFFF, 3'd7);
    send_request(REQ_OPC_LAST - 5'd1, 16'd0, 3'd1);
  endtask

  task automatic test_all_opcodes();
    for (int op = 0; op <= REQ_OPC_LAST; op++) begin
      send_request(5'(op), 16'($urandom_range(3)), 3'($urandom_range(7)));
    end
  endtask

  // Random instructions, biased toward small shift counts and edge operands.
  task automatic test_random_mix(int count);
    logic [15:0] src;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: src = 16'($urandom_range(20));
        1: src = $urandom_range(1) ? 16'h8000 : 16'hFFFF;
        2: src = 16'($urandom_range(1));
        default: src = 16'($urandom);
      endcase
      quiet_mode = (i >= count / 2) && (i < count / 2 + 150);
      send_request(5'($urandom), src, 3'($urandom));
    end
    quiet_mode = 0;
  endtask

  // Hold the result side off so the block backs up into its input.
  task automatic test_backpressure();
    hold_pop = 1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_pop = 0;
      end
      test_random_mix(20);
    join
  endtask

  // Pop results and compare them with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result %h", out_result_value);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_result_value !== exp_r.value || out_carry_flag !== exp_r.cf ||
              out_zero_flag !== exp_r.zf || out_sign_flag !== exp_r.sf ||
              out_overflow_flag !== exp_r.of || out_divide_error !== exp_r.derr) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected %h c%b z%b s%b o%b e%b, got %h c%b z%b s%b o%b e%b",
                       exp_r.value, exp_r.cf, exp_r.zf, exp_r.sf, exp_r.of, exp_r.derr,
                       out_result_value, out_carry_flag, out_zero_flag, out_sign_flag,
                       out_overflow_flag, out_divide_error);
            end
          end
        end
      end
      out_pop <= !hold_pop && (quiet_mode || $urandom_range(99) >= 6);
    end
  end

  // Watchdog on cycles without any accepted request or popped result.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_req_type = '0;
    in_source_operand = '0;
    in_dest_index = '0;
    out_pop = 1'b0;
    mismatch_count = 0;
    quiet_mode = 0;
    hold_pop = 0;
    idle_cycles = 0;
    timed_out = 0;
    for (int i = 0; i < NREGS; i++) shadow_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_all_opcodes();
    test_backpressure();
    test_random_mix(1150);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
